// ----- design/cspe_pkg.sv -----
package cspe_pkg;

	localparam int MaxPointsDef = 256;
	localparam int CoordW = 32;
	localparam int ScaleResetVal = 65536;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_EVAL   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	localparam logic [0:0] REG_CLOSED = 1'b0;
	localparam logic [0:0] REG_SCALE  = 1'b1;

	// shared multiplier request
	typedef struct packed {
		logic signed [39:0] a;
		logic [16:0]        b;
	} mul_req_t;

endpackage

// ----- design/cspe_if.sv -----
interface cspe_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic [31:0] time_value;
	modport source(output valid, operation, point_x, point_y, point_z, time_value, input ready);
	modport sink(input valid, operation, point_x, point_y, point_z, time_value, output ready);
endinterface

interface cspe_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic        curve_ready;
	modport source(output valid, pos_x, pos_y, pos_z, curve_ready, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, curve_ready, output ready);
endinterface

// ----- design/cubic_spline_path_evaluator_unit.sv -----
// clear, append and unused codes give no result; evaluate has its result after a time multiply,
// a remainder by the point count, 4 point reads, then per axis: coefficients,
// 3 horner steps on the shared multiplier, rounding
// an evaluate with fewer than two points has its result in the cycle after acceptance
// one transaction at a time; the next is accepted only after the result is taken
// reset: point count, closed_loop and control clear, time_scale to 1.0, store undefined
module cubic_spline_path_evaluator_unit #(
	parameter int MAX_POINTS = cspe_pkg::MaxPointsDef,
	localparam int IdxW = $clog2(MAX_POINTS),
	localparam int CntW = $clog2(MAX_POINTS + 1)
) (
	input  logic        clk,
	input  logic        arst_n,
	cspe_in_if.sink     in_ch,
	cspe_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import cspe_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_TMUL, ST_MOD, ST_RD, ST_COEF, ST_HMUL, ST_HADD, ST_AXIS, ST_OUT
	} state_t;

	state_t state_q;
	logic              closed_q;
	logic [31:0]       scale_q;
	logic [CntW-1:0]   count_q;
	logic [95:0]       mem [MAX_POINTS];
	logic [95:0]       rd_s1;
	logic [IdxW-1:0]   rd_addr;
	logic [63:0]       tprod_q;
	logic [31:0]       rem_q;
	logic [5:0]        bit_q;
	logic [15:0]       frac_q;
	logic [IdxW-1:0]   seg_q;
	logic [1:0]        rd_q;    // which neighbor is being fetched
	logic [1:0]        rd_cap_q;
	logic              rd_pend_q;
	logic [95:0]       pt_q [4]; // prev, p0, p1, next-of-p1
	logic [1:0]        axis_q;
	logic [1:0]        step_q;
	logic signed [39:0] c_q [3];
	logic signed [39:0] acc_q;
	logic signed [31:0] res_q [3];
	logic              cready_q;
	logic              wr_en;
	mul_req_t          mreq;
	logic signed [57:0] prod_s1;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	always_comb begin
		case (paddr[2])
			REG_CLOSED: prdata = {31'd0, closed_q};
			default:    prdata = scale_q;
		endcase
	end

	cspe_mul u_mul (.clk(clk), .req(mreq), .prod_s1(prod_s1));

	// neighbor indexes around the segment
	logic [IdxW-1:0] last_idx, s_prev, s_next, s_next2;
	always_comb begin
		last_idx = IdxW'(count_q - CntW'(1));
		if (seg_q == '0) s_prev = closed_q ? last_idx : '0;
		else s_prev = seg_q - IdxW'(1);
		if (seg_q == last_idx) s_next = closed_q ? '0 : last_idx;
		else s_next = seg_q + IdxW'(1);
		// tangent at (s+1) mod n uses next of that point
		if (seg_q == last_idx) s_next2 = (closed_q || count_q > CntW'(1)) ? IdxW'(1) : '0;
		else if (s_next == last_idx) s_next2 = closed_q ? '0 : last_idx;
		else s_next2 = s_next + IdxW'(1);
		if (seg_q == last_idx && count_q == CntW'(2) && !closed_q) s_next2 = IdxW'(1);
		case (rd_q)
			2'd0: rd_addr = s_prev;
			2'd1: rd_addr = seg_q;
			2'd2: rd_addr = (seg_q == last_idx) ? '0 : s_next;
			default: rd_addr = s_next2;
		endcase
	end

	// point store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_ch.valid && in_ch.ready &&
		    in_ch.operation == OP_APPEND && count_q < CntW'(MAX_POINTS))
			mem[IdxW'(count_q)] <= {in_ch.point_z, in_ch.point_y, in_ch.point_x};
		rd_s1 <= mem[rd_addr];
	end

	// axis values and coefficient math (one axis at a time)
	logic signed [33:0] vprev, v0, v1, vnx, vq1, d0, d1;
	logic signed [39:0] c2w, c3w;
	always_comb begin
		vprev = 34'(signed'(pt_q[0][32*axis_q +: 32]));
		v0    = 34'(signed'(pt_q[1][32*axis_q +: 32]));
		vq1   = 34'(signed'(pt_q[2][32*axis_q +: 32]));
		vnx   = 34'(signed'(pt_q[3][32*axis_q +: 32]));
		// open last segment runs from the last point to itself
		v1 = (seg_q == last_idx && !closed_q) ? v0 : vq1;
		d0 = v1 - vprev;
		// open last segment ends on point 0's tangent, whose previous point is point 0
		d1 = vnx - ((seg_q == last_idx && !closed_q) ? vq1 : v0);
		c2w = 40'sd6 * 40'(v1 - v0) - 40'sd2 * 40'(d0) - 40'(d1);
		c3w = 40'sd4 * 40'(v0 - v1) + 40'(d0) + 40'(d1);
	end

	logic signed [57:0] rnd;
	logic signed [40:0] half;
	assign rnd = prod_s1 + 58'sd32768;
	assign half = 41'(acc_q) + 41'sd1;
	assign mreq.a = (state_q == ST_TMUL) ? 40'(signed'({1'b0, in_ch.time_value})) : acc_q;
	assign mreq.b = {1'b0, frac_q};

	logic [32:0] rem_sh;
	logic [31:0] rem_nx;
	assign rem_sh = {rem_q, tprod_q[63 - bit_q]};
	assign rem_nx = (rem_sh >= 33'(count_q)) ? 32'(rem_sh - 33'(count_q)) : rem_sh[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			closed_q <= 1'b0;
			scale_q  <= 32'(ScaleResetVal);
			count_q  <= '0;
			out_ch.valid <= 1'b0;
			in_ch.ready  <= 1'b0;
		end else begin
			if (wr_en && paddr[2] == REG_CLOSED) closed_q <= pwdata[0];
			if (wr_en && paddr[2] == REG_SCALE) scale_q <= pwdata;
			unique case (state_q)
				ST_IDLE: begin
					in_ch.ready <= 1'b1;
					if (in_ch.valid && in_ch.ready) begin
						in_ch.ready <= 1'b0;
						case (in_ch.operation)
							OP_CLEAR: count_q <= '0;
							OP_APPEND: if (count_q < CntW'(MAX_POINTS)) count_q <= count_q + CntW'(1);
							OP_EVAL: begin
								if (count_q < CntW'(2)) begin
									res_q[0] <= '0; res_q[1] <= '0; res_q[2] <= '0;
									cready_q <= 1'b0;
									out_ch.valid <= 1'b1;
									state_q <= ST_OUT;
								end else begin
									tprod_q <= 64'(in_ch.time_value) * 64'(scale_q);
									state_q <= ST_TMUL;
								end
							end
							default: ;
						endcase
					end
				end
				ST_TMUL: begin
					frac_q <= tprod_q[31:16];
					rem_q <= '0;
					bit_q <= '0;
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					// restoring remainder, one bit of the integer part a cycle
					rem_q <= rem_nx;
					bit_q <= bit_q + 6'd1;
					if (bit_q == 6'd31) begin
						seg_q <= IdxW'(rem_nx);
						rd_q <= 2'd0; rd_pend_q <= 1'b0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					rd_pend_q <= 1'b1;
					rd_cap_q <= rd_q;
					if (rd_pend_q) pt_q[rd_cap_q] <= rd_s1;
					if (rd_q == 2'd3 && rd_pend_q && rd_cap_q == 2'd3) begin
						axis_q <= 2'd0;
						state_q <= ST_COEF;
					end else if (rd_q != 2'd3) rd_q <= rd_q + 2'd1;
				end
				ST_COEF: begin
					acc_q <= c3w;
					c_q[0] <= 40'(v0) <<< 1;
					c_q[1] <= 40'(d0);
					c_q[2] <= c2w;
					step_q <= 2'd2;
					state_q <= ST_HMUL;
				end
				ST_HMUL: state_q <= ST_HADD;
				ST_HADD: begin
					acc_q <= c_q[step_q] + 40'(rnd >>> 16);
					if (step_q == 2'd0) state_q <= ST_AXIS;
					else begin
						step_q <= step_q - 2'd1;
						state_q <= ST_HMUL;
					end
				end
				ST_AXIS: begin
					if (half[40:32] != {9{half[40]}})
						res_q[axis_q] <= half[40] ? 32'sh80000000 : 32'sh7fffffff;
					else res_q[axis_q] <= half[32:1];
					if (axis_q == 2'd2) begin
						cready_q <= 1'b1;
						out_ch.valid <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						axis_q <= axis_q + 2'd1;
						state_q <= ST_COEF;
					end
				end
				ST_OUT: if (out_ch.ready) begin
					out_ch.valid <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.pos_x = res_q[0];
	assign out_ch.pos_y = res_q[1];
	assign out_ch.pos_z = res_q[2];
	assign out_ch.curve_ready = cready_q;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid)) else $error("input taken while result pending");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MAX_POINTS)) else $error("point count overflow");
	a_ready_pts: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.curve_ready |-> count_q >= CntW'(2))
		else $error("curve ready with too few points");
endmodule

// ----- design/cspe_mul.sv -----
module cspe_mul (
	input  logic                 clk,
	input  cspe_pkg::mul_req_t   req,
	output logic signed [57:0]   prod_s1
);
	import cspe_pkg::*;

	// one registered signed by unsigned multiply, shared by all horner steps of every axis
	always_ff @(posedge clk) begin
		prod_s1 <= 58'(req.a * $signed({1'b0, req.b}));
	end
endmodule
